@@ src/ascii_set_command_pwm_registers_assert.svh @@
// assertion macros shared by the ascii set command pwm register block
`ifndef ASCII_SET_COMMAND_PWM_REGISTERS_ASSERT_SVH
`define ASCII_SET_COMMAND_PWM_REGISTERS_ASSERT_SVH

// clocked check, quiet while reset is applied
`define ASCPWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define ASCPWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ascpwm_pkg.sv @@
// shared types, constants and helpers of the ascii set command pwm register block
`default_nettype none

package ascpwm_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // parse check levels
    localparam logic [1:0] CHK_FAIL   = 2'd0;
    localparam logic [1:0] CHK_PREFIX = 2'd1;
    localparam logic [1:0] CHK_EQ     = 2'd2;
    localparam logic [1:0] CHK_COLON  = 2'd3;

    // byte positions within a message
    localparam logic [3:0] POS_P0      = 4'd0;
    localparam logic [3:0] POS_P1      = 4'd1;
    localparam logic [3:0] POS_P2      = 4'd2;
    localparam logic [3:0] POS_P3      = 4'd3;
    localparam logic [3:0] POS_P4      = 4'd4;
    localparam logic [3:0] POS_ID      = 4'd5;
    localparam logic [3:0] POS_DOT     = 4'd6;
    localparam logic [3:0] POS_CH0     = 4'd7;
    localparam logic [3:0] POS_CH1     = 4'd8;
    localparam logic [3:0] POS_EQ      = 4'd9;
    localparam logic [3:0] POS_V0      = 4'd10;
    localparam logic [3:0] POS_V1      = 4'd11;
    localparam logic [3:0] POS_V2      = 4'd12;
    localparam logic [3:0] POS_V3      = 4'd13;
    localparam logic [3:0] POS_COLON   = 4'd14;
    localparam logic [3:0] POS_MAX     = 4'd15;
    localparam logic [3:0] POS_COMMIT  = 4'd7;

    localparam logic [3:0] MAX_ID = 4'd9;

    // ascii characters
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_X     = 8'h58;
    localparam logic [7:0] CHAR_XX_LO = 8'h58;
    localparam logic [7:0] CHAR_CHMAX = 8'(48 + NUM_CHANNELS);

    localparam logic [13:0] DUTY_MAX = 14'd255;
    localparam logic [1:0]  ECHO_LEN_RESET = 2'd2;
    localparam logic [1:0]  ECHO_LEN_FULL  = 2'd2;

    // event handed from the parser to the reply stage
    typedef struct packed {
        logic        kind;
        logic [2:0]  channel;
        logic [3:0]  id;
        logic [15:0] echo;
        logic [1:0]  echo_len;
        logic        done;
    } evt_t;

    // characters of the "/SET." prefix
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2F;
            3'd1:    c = 8'h53;
            3'd2:    c = 8'h45;
            3'd3:    c = 8'h54;
            default: c = 8'h2E;
        endcase
        return c;
    endfunction

    // ascii digit for the module id, no range check
    function automatic logic [7:0] id_char(input logic [3:0] id);
        return CHAR_0 + {4'b0000, id};
    endfunction

endpackage

`default_nettype wire

@@ src/ascpwm_if.sv @@
// valid/ready channel interfaces for message words and result words
`default_nettype none

interface ascpwm_msg_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output cmd, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input cmd, input rx_byte, input rx_last, output ready);
endinterface

interface ascpwm_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [2:0] channel;
    logic [7:0] duty;

    modport source (output valid, output kind, output tx_byte, output tx_last,
                    output channel, output duty, input ready);
    modport sink   (input valid, input kind, input tx_byte, input tx_last,
                    input channel, input duty, output ready);
endinterface

`default_nettype wire

@@ src/ascpwm_parser.sv @@
// message parser, module id register, echo capture and duty register store
`default_nettype none

`include "ascii_set_command_pwm_registers_assert.svh"

module ascpwm_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [3:0]        cfg_data,
    input  wire logic              accept,
    input  wire logic              cmd,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              rx_last,
    input  wire logic [2:0]        rd_ch,
    output logic [7:0]             rd_duty,
    output logic                   ev_push,
    output ascpwm_pkg::evt_t       ev
);

    logic [3:0]  module_id_reg;
    logic [3:0]  pos_reg;
    logic        start_reg;
    logic [1:0]  chk_reg;
    logic [15:0] cap_reg;
    logic [1:0]  caplen_reg;
    logic [15:0] echo_reg;
    logic [1:0]  echolen_reg;
    logic [13:0] acc_reg;
    logic        stop_reg;
    logic        done_reg;
    logic [7:0]  duty_reg [ascpwm_pkg::NUM_CHANNELS];

    logic [3:0]  p;
    logic [1:0]  chk_next;
    logic [15:0] cap_next;
    logic [1:0]  caplen_next;
    logic [13:0] acc_next;
    logic        stop_next;
    logic [3:0]  pos_next;
    logic [13:0] acc_x10;
    logic [7:0]  digit_diff;
    logic        is_digit;
    logic [7:0]  ch_digit;
    logic [7:0]  ch_idx;
    logic        ch_ok;
    logic        commit_echo;
    logic        is_read;
    logic        is_byte;
    logic        upd;

    // a new message starts from cleared parse state
    always_comb
    begin
        p           = start_reg ? ascpwm_pkg::POS_P0 : pos_reg;
        chk_next    = start_reg ? ascpwm_pkg::CHK_PREFIX : chk_reg;
        cap_next    = start_reg ? 16'h0000 : cap_reg;
        caplen_next = start_reg ? 2'd0 : caplen_reg;
        acc_next    = start_reg ? 14'd0 : acc_reg;
        stop_next   = start_reg ? 1'b0 : stop_reg;

        acc_x10    = 14'((acc_next << 3) + (acc_next << 1));
        digit_diff = rx_byte - ascpwm_pkg::CHAR_0;
        is_digit   = (rx_byte >= ascpwm_pkg::CHAR_0) && (rx_byte <= ascpwm_pkg::CHAR_9);

        case (p) inside
            ascpwm_pkg::POS_P0, ascpwm_pkg::POS_P1, ascpwm_pkg::POS_P2,
            ascpwm_pkg::POS_P3, ascpwm_pkg::POS_P4:
            begin
                if (rx_byte != ascpwm_pkg::prefix_char(p[2:0]))
                begin
                    chk_next = ascpwm_pkg::CHK_FAIL;
                end
            end
            ascpwm_pkg::POS_ID:
            begin
                if ((module_id_reg > ascpwm_pkg::MAX_ID) ||
                    (rx_byte != ascpwm_pkg::id_char(module_id_reg)))
                begin
                    chk_next = ascpwm_pkg::CHK_FAIL;
                end
            end
            ascpwm_pkg::POS_DOT:
            begin
                if (rx_byte != ascpwm_pkg::CHAR_DOT)
                begin
                    chk_next = ascpwm_pkg::CHK_FAIL;
                end
            end
            ascpwm_pkg::POS_CH0:
            begin
                cap_next[7:0] = cap_next[7:0] | rx_byte;
                caplen_next   = caplen_next + 2'd1;
            end
            ascpwm_pkg::POS_CH1:
            begin
                cap_next[15:8] = cap_next[15:8] | rx_byte;
                caplen_next    = caplen_next + 2'd1;
            end
            ascpwm_pkg::POS_EQ:
            begin
                if ((chk_next == ascpwm_pkg::CHK_PREFIX) && (rx_byte == ascpwm_pkg::CHAR_EQ))
                begin
                    chk_next = ascpwm_pkg::CHK_EQ;
                end
            end
            ascpwm_pkg::POS_V0, ascpwm_pkg::POS_V1, ascpwm_pkg::POS_V2, ascpwm_pkg::POS_V3:
            begin
                if (!stop_next && is_digit)
                begin
                    acc_next = acc_x10 + {10'd0, digit_diff[3:0]};
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end
            ascpwm_pkg::POS_COLON:
            begin
                if ((chk_next == ascpwm_pkg::CHK_EQ) && (rx_byte == ascpwm_pkg::CHAR_COLON))
                begin
                    chk_next = ascpwm_pkg::CHK_COLON;
                end
            end
            default:
            begin
            end
        endcase

        pos_next = (p < ascpwm_pkg::POS_MAX) ? p + 4'd1 : p;
    end

    assign commit_echo = (chk_next != ascpwm_pkg::CHK_FAIL) && (pos_next >= ascpwm_pkg::POS_COMMIT);
    assign ch_digit    = cap_next[15:8];
    assign ch_idx      = ch_digit - ascpwm_pkg::CHAR_1;
    assign ch_ok       = (chk_next == ascpwm_pkg::CHK_COLON) && (caplen_next == 2'd2) &&
                         (cap_next[7:0] == ascpwm_pkg::CHAR_0) &&
                         (ch_digit >= ascpwm_pkg::CHAR_1) &&
                         (ch_digit <= ascpwm_pkg::CHAR_CHMAX) &&
                         (acc_next <= ascpwm_pkg::DUTY_MAX);

    assign is_read = accept && (cmd == ascpwm_pkg::CMD_READ);
    assign is_byte = accept && (cmd == ascpwm_pkg::CMD_BYTE);
    assign upd     = is_byte && rx_last && ch_ok;
    assign ev_push = is_read || upd;

    always_comb
    begin
        ev.kind     = is_read ? ascpwm_pkg::KIND_REPLY : ascpwm_pkg::KIND_UPDATE;
        ev.channel  = ch_idx[2:0];
        ev.id       = module_id_reg;
        ev.echo     = echo_reg;
        ev.echo_len = echolen_reg;
        ev.done     = done_reg;
    end

    assign rd_duty = duty_reg[rd_ch[ascpwm_pkg::CH_IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_id_reg <= 4'd1;
            pos_reg       <= 4'd0;
            start_reg     <= 1'b1;
            chk_reg       <= ascpwm_pkg::CHK_FAIL;
            cap_reg       <= 16'h0000;
            caplen_reg    <= 2'd0;
            echo_reg      <= {ascpwm_pkg::CHAR_X, ascpwm_pkg::CHAR_XX_LO};
            echolen_reg   <= ascpwm_pkg::ECHO_LEN_RESET;
            acc_reg       <= 14'd0;
            stop_reg      <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < ascpwm_pkg::NUM_CHANNELS; i++)
            begin
                duty_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                module_id_reg <= cfg_data;
            end
            if (is_read)
            begin
                done_reg <= 1'b0;
            end
            if (is_byte)
            begin
                pos_reg    <= pos_next;
                chk_reg    <= chk_next;
                cap_reg    <= cap_next;
                caplen_reg <= caplen_next;
                acc_reg    <= acc_next;
                stop_reg   <= stop_next;
                start_reg  <= rx_last;
                if (rx_last)
                begin
                    done_reg <= upd;
                    if (commit_echo)
                    begin
                        echo_reg    <= cap_next;
                        echolen_reg <= caplen_next;
                    end
                end
            end
            if (upd)
            begin
                duty_reg[ch_idx[ascpwm_pkg::CH_IDX_W-1:0]] <= acc_next[7:0];
            end
        end
    end

    `ASCPWM_ASSERT(a_upd_channel_range, upd |-> (ev.channel < 3'(ascpwm_pkg::NUM_CHANNELS)), "update channel out of range")
    `ASCPWM_ASSERT(a_upd_sets_done, upd |=> done_reg, "done flag not set after update")
    `ASCPWM_ASSERT(a_read_clears_done, is_read |=> !done_reg, "done flag not cleared by read")

endmodule

`default_nettype wire

@@ src/ascpwm_reply.sv @@
// event stage, reply byte sequencer and result output register
`default_nettype none

`include "ascii_set_command_pwm_registers_assert.svh"

module ascpwm_reply (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ev_push,
    input  wire ascpwm_pkg::evt_t  ev,
    output logic                   take,
    output logic [2:0]             rd_ch,
    input  wire logic [7:0]        rd_duty,
    ascpwm_res_if.source           res
);

    typedef enum logic [9:0] {
        ST_ID    = 10'b00_0000_0001,
        ST_DOT0  = 10'b00_0000_0010,
        ST_ECHO0 = 10'b00_0000_0100,
        ST_ECHO1 = 10'b00_0000_1000,
        ST_DOT1  = 10'b00_0001_0000,
        ST_T0    = 10'b00_0010_0000,
        ST_T1    = 10'b00_0100_0000,
        ST_T2    = 10'b00_1000_0000,
        ST_T3    = 10'b01_0000_0000,
        ST_SEMI  = 10'b10_0000_0000
    } step_t;

    logic             ev_valid_reg;
    ascpwm_pkg::evt_t ev_reg;
    step_t            step_reg;
    step_t            step_next;
    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic [2:0]       out_ch_reg;
    logic [7:0]       out_duty_reg;

    logic       out_load;
    logic       advance;
    logic       last_step;
    logic [7:0] reply_byte;

    assign out_load  = !out_valid_reg || res.ready;
    assign advance   = ev_valid_reg && out_load;
    assign last_step = (ev_reg.kind == ascpwm_pkg::KIND_UPDATE) || (step_reg == ST_SEMI);
    assign take      = !ev_valid_reg || (advance && last_step);
    assign rd_ch     = ev_reg.channel;

    always_comb
    begin
        reply_byte = ascpwm_pkg::CHAR_SEMI;
        step_next  = ST_SEMI;
        unique case (step_reg)
            ST_ID:
            begin
                reply_byte = ascpwm_pkg::id_char(ev_reg.id);
                step_next  = ST_DOT0;
            end
            ST_DOT0:
            begin
                reply_byte = ascpwm_pkg::CHAR_DOT;
                step_next  = (ev_reg.echo_len != 2'd0) ? ST_ECHO0 : ST_DOT1;
            end
            ST_ECHO0:
            begin
                reply_byte = ev_reg.echo[7:0];
                step_next  = (ev_reg.echo_len >= ascpwm_pkg::ECHO_LEN_FULL) ? ST_ECHO1 : ST_DOT1;
            end
            ST_ECHO1:
            begin
                reply_byte = ev_reg.echo[15:8];
                step_next  = ST_DOT1;
            end
            ST_DOT1:
            begin
                reply_byte = ascpwm_pkg::CHAR_DOT;
                step_next  = ST_T0;
            end
            ST_T0:
            begin
                reply_byte = ev_reg.done ? 8'h44 : ascpwm_pkg::CHAR_X;
                step_next  = ST_T1;
            end
            ST_T1:
            begin
                reply_byte = ev_reg.done ? 8'h4F : ascpwm_pkg::CHAR_X;
                step_next  = ST_T2;
            end
            ST_T2:
            begin
                reply_byte = ev_reg.done ? 8'h4E : ascpwm_pkg::CHAR_X;
                step_next  = ST_T3;
            end
            ST_T3:
            begin
                reply_byte = ev_reg.done ? 8'h45 : ascpwm_pkg::CHAR_X;
                step_next  = ST_SEMI;
            end
            ST_SEMI:
            begin
                reply_byte = ascpwm_pkg::CHAR_SEMI;
                step_next  = ST_SEMI;
            end
            default:
            begin
                reply_byte = ascpwm_pkg::CHAR_SEMI;
                step_next  = ST_SEMI;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            step_reg      <= ST_ID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_push)
            begin
                ev_valid_reg <= 1'b1;
                step_reg     <= ST_ID;
            end
            else if (advance && last_step)
            begin
                ev_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                step_reg <= step_next;
            end
            if (out_load)
            begin
                out_valid_reg <= ev_valid_reg;
            end
        end
    end

    // payload of the event and result registers
    always_ff @(posedge clk)
    begin
        if (ev_push)
        begin
            ev_reg <= ev;
        end
        if (advance)
        begin
            out_kind_reg <= ev_reg.kind;
            if (ev_reg.kind == ascpwm_pkg::KIND_UPDATE)
            begin
                out_byte_reg <= 8'h00;
                out_last_reg <= 1'b0;
                out_ch_reg   <= ev_reg.channel;
                out_duty_reg <= rd_duty;
            end
            else
            begin
                out_byte_reg <= reply_byte;
                out_last_reg <= (step_reg == ST_SEMI);
                out_ch_reg   <= 3'd0;
                out_duty_reg <= 8'h00;
            end
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.kind    = out_kind_reg;
    assign res.tx_byte = out_byte_reg;
    assign res.tx_last = out_last_reg;
    assign res.channel = out_ch_reg;
    assign res.duty    = out_duty_reg;

    `ASCPWM_ASSERT(a_push_only_when_free, ev_push |-> take, "event pushed while stage busy")
    `ASCPWM_ASSERT(a_update_single_step, (ev_valid_reg && (ev_reg.kind == ascpwm_pkg::KIND_UPDATE)) |-> (step_reg == ST_ID), "update event left first step")
    `ASCPWM_ASSERT(a_semi_closes_reply, (advance && (ev_reg.kind == ascpwm_pkg::KIND_REPLY) && (step_reg == ST_SEMI)) |=> (out_valid_reg && out_last_reg), "reply closed without last flag")
    `ASCPWM_ASSERT(a_last_only_reply, (out_valid_reg && out_last_reg) |-> (out_kind_reg == ascpwm_pkg::KIND_REPLY), "last flag on an update word")

endmodule

`default_nettype wire

@@ src/ascii_set_command_pwm_registers.sv @@
// top level of the ascii set command pwm register block
// -----------------------------------------------------------------------------
// parses "/SET.d.nn=vvvv:" write messages one byte word per cycle and keeps
// six 8-bit duty registers. a message byte is taken every cycle while the
// result side keeps up; a valid message ending on rx_last gives one update word
// on res (event register, then result register), channel zero based, new duty.
// a read request (cmd high) gives the reply "d.nn.DONE;" or "d.nn.XXXX;" as 8
// to 10 byte words, one per cycle while the result side keeps up, and clears
// the done flag; msg.ready stays low while the reply sequencer walks through
// its bytes. module_id is written through cfg_we/cfg_data; the user is to do so
// only while the block is idle, the block itself does not enforce it. there is
// no clearing pass: control and duty state resets at once; payload regs do not.
// -----------------------------------------------------------------------------
`default_nettype none

module ascii_set_command_pwm_registers (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data,
    ascpwm_msg_if.sink      msg,
    ascpwm_res_if.source    res
);

    // handshake between parser and reply stage
    logic             take;
    logic             accept;
    logic             ev_push;
    ascpwm_pkg::evt_t ev;

    // duty register read for update words
    logic [2:0] rd_ch;
    logic [7:0] rd_duty;

    // a word enters whenever the event stage is free or draining its last word
    assign msg.ready = take;
    assign accept    = msg.valid && take;

    // parse state, echo capture, done flag and duty store
    ascpwm_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .cmd      (msg.cmd),
        .rx_byte  (msg.rx_byte),
        .rx_last  (msg.rx_last),
        .rd_ch    (rd_ch),
        .rd_duty  (rd_duty),
        .ev_push  (ev_push),
        .ev       (ev)
    );

    // event register, reply sequencer and result register
    ascpwm_reply u_reply (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_push  (ev_push),
        .ev       (ev),
        .take     (take),
        .rd_ch    (rd_ch),
        .rd_duty  (rd_duty),
        .res      (res)
    );

endmodule

`default_nettype wire
